/* design/crcfg_pkg.sv */
// Shared types, codes and the CRC byte update for the CRC-16 frame unit.
// No dependencies; compiled first.
package crcfg_pkg;

  localparam logic [15:0] CRC_POLY = 16'h9299;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  // out_kind codes
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_CRC     = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  // check_status codes
  localparam logic [1:0] STAT_MATCH    = 2'd0;
  localparam logic [1:0] STAT_MISMATCH = 2'd1;
  localparam logic [1:0] STAT_SHORT    = 2'd2;

  // frame_mode values
  localparam logic MODE_GEN   = 1'b0;
  localparam logic MODE_CHECK = 1'b1;

  // First result of one request, plus a flag for the two CRC bytes after it
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic [1:0] kind;
    logic [1:0] status;
    logic       last;
    logic       tail;
  } res_t;

  // Reflected CRC update over one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  b);
    logic [15:0] c;
    logic        fb;
    c = crc_in;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c  = {1'b0, c[15:1]};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

/* design/crcfg_frame.sv */
// Frame state of the CRC-16 unit: mode, running CRC and two-byte delay line.
// Depends on crcfg_pkg.
module crcfg_frame (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              op_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  output crcfg_pkg::res_t   res_o,
  output logic [15:0]       crc_o
);
  import crcfg_pkg::*;

  logic [15:0] crc_q, crc_d;
  logic [7:0]  held0_q, held0_d, held1_q, held1_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        mode_q, mode_d;
  logic        in_frame_q, in_frame_d;

  logic [15:0] crc_base;
  logic [7:0]  held0_base, held1_base;
  logic [1:0]  cnt_base;

  always_comb begin
    // a new frame starts from a clean slate
    mode_d     = in_frame_q ? mode_q  : op_i;
    crc_base   = in_frame_q ? crc_q   : CRC_INIT;
    held0_base = in_frame_q ? held0_q : 8'd0;
    held1_base = in_frame_q ? held1_q : 8'd0;
    cnt_base   = in_frame_q ? cnt_q   : 2'd0;

    crc_d      = crc_base;
    held0_d    = held0_base;
    held1_d    = held1_base;
    cnt_d      = cnt_base;
    in_frame_d = !last_byte_i;

    res_o        = '0;
    res_o.data   = data_byte_i;
    res_o.kind   = KIND_PAYLOAD;
    res_o.status = STAT_MATCH;

    if (mode_d == MODE_GEN) begin
      crc_d       = crc_byte(crc_base, data_byte_i);
      res_o.valid = 1'b1;
      res_o.tail  = last_byte_i;
    end else begin
      if (cnt_base == 2'd2) begin
        // shift the oldest held byte into the CRC
        crc_d   = crc_byte(crc_base, held0_base);
        held0_d = held1_base;
        held1_d = data_byte_i;
      end else begin
        if (cnt_base[0]) begin
          held1_d = data_byte_i;
        end else begin
          held0_d = data_byte_i;
        end
        cnt_d = cnt_base + 2'd1;
      end
      res_o.valid = last_byte_i;
      res_o.data  = 8'd0;
      res_o.kind  = KIND_VERDICT;
      res_o.last  = 1'b1;
      if (cnt_d != 2'd2) begin
        res_o.status = STAT_SHORT;
      end else if ({held0_d, held1_d} == crc_d) begin
        res_o.status = STAT_MATCH;
      end else begin
        res_o.status = STAT_MISMATCH;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= CRC_INIT;
      held0_q    <= 8'd0;
      held1_q    <= 8'd0;
      cnt_q      <= 2'd0;
      mode_q     <= MODE_GEN;
      in_frame_q <= 1'b0;
    end else if (accept_i) begin
      crc_q      <= crc_d;
      held0_q    <= held0_d;
      held1_q    <= held1_d;
      cnt_q      <= cnt_d;
      mode_q     <= mode_d;
      in_frame_q <= in_frame_d;
    end
  end

  assign crc_o = crc_q;

endmodule

/* design/crc16_frame_generate_check_unit.sv */
// Top level of the CRC-16 frame generate/check unit.
// Depends on crcfg_pkg and crcfg_frame.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one frame byte per
//   request: op_i, data_byte_i, last_byte_i. The op of a frame's first byte
//   selects generate (append CRC) or check (verify trailing CRC).
//   Output channel (out_valid_o / out_stall_i) carries results: payload
//   bytes, CRC bytes (high byte first) and check verdicts.
//   A result is registered and appears in the cycle after its request is accepted.
//   One byte is accepted per cycle while the input is not stalled. The last
//   byte of a generate frame yields three results, so the input stalls
//   while the two CRC bytes leave the output register. Check-mode bytes other than
//   the last give no result.
//   The CRC update over one byte is eight unrolled XOR steps between the
//   input and the frame state registers.
//   A stalled output holds its result and stalls the input in turn; the
//   output register lets a new request in during the cycle its result
//   is taken.
//   Reset clears the frame state and the output valid and pending-CRC flags; the next
//   accepted byte starts a new frame.
module crc16_frame_generate_check_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       op_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] out_kind_o,
  output logic [1:0] check_status_o,
  output logic       out_last_o
);
  import crcfg_pkg::*;

  res_t        res;
  logic [15:0] crc;
  logic        in_acc;
  logic        out_take;

  logic       out_valid_q, out_valid_d;
  logic [1:0] pend_q, pend_d;      // CRC bytes still to send
  logic [7:0] byte_q, byte_d;
  logic [1:0] kind_q, kind_d;
  logic [1:0] stat_q, stat_d;
  logic       last_q, last_d;

  // hold input while CRC bytes drain or the output is blocked
  assign in_stall_o = (pend_q != 2'd0) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;

  crcfg_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .op_i        (op_i),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .res_o       (res),
    .crc_o       (crc)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    pend_d      = pend_q;
    byte_d      = byte_q;
    kind_d      = kind_q;
    stat_d      = stat_q;
    last_d      = last_q;

    if (out_take) begin
      out_valid_d = 1'b0;
      if (pend_q != 2'd0) begin
        // advance to the next CRC byte, high byte first
        out_valid_d = 1'b1;
        pend_d      = pend_q - 2'd1;
        kind_d      = KIND_CRC;
        stat_d      = STAT_MATCH;
        byte_d      = (pend_q == 2'd2) ? crc[15:8] : crc[7:0];
        last_d      = (pend_q == 2'd1);
      end
    end

    if (in_acc && res.valid) begin
      out_valid_d = 1'b1;
      pend_d      = res.tail ? 2'd2 : 2'd0;
      byte_d      = res.data;
      kind_d      = res.kind;
      stat_d      = res.status;
      last_d      = res.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    kind_q <= kind_d;
    stat_q <= stat_d;
    last_q <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = byte_q;
  assign out_kind_o     = kind_q;
  assign check_status_o = stat_q;
  assign out_last_o     = last_q;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for crc16_frame_generate_check_unit.
// Holds its own CRC-16 frame predictor and drives random frames under back-pressure.
// Depends on crcfg_pkg and the unit's RTL only.
module testbench;
  import crcfg_pkg::*;

  // Reflected polynomial and seed used by the predictor
  localparam logic [15:0] POLY_REFL = 16'h9299;
  localparam logic [15:0] CRC_SEED  = 16'h0000;

  localparam int HOLD_OFF_CYCLES = 60;
  localparam int DRAIN_LIMIT     = 2000;
  localparam int TAIL_CYCLES     = 10;
  localparam int MAX_REPORTS     = 10;
  localparam int TIMEOUT_UNITS   = 400000;

  // How the tail of a check frame is built
  localparam int TAIL_RANDOM  = 0;
  localparam int TAIL_GOOD    = 1;
  localparam int TAIL_CORRUPT = 2;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic [1:0] status;
    logic       last;
  } frame_result_t;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic       op_i        = 1'b0;
  logic [7:0] data_byte_i = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic [1:0] out_kind_o;
  logic [1:0] check_status_o;
  logic       out_last_o;

  // Predictor state: mirrors the unit's frame state
  logic [15:0] crc_m;
  logic [7:0]  held_m [2];
  logic [1:0]  held_n_m;
  logic        mode_m;
  logic        in_frame_m = 1'b0;

  frame_result_t pending_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_seq      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  int error_count    = 0;
  int requests_sent  = 0;
  int results_seen   = 0;
  int gen_frames     = 0;
  int chk_frames     = 0;
  int match_verdicts = 0;
  int bad_verdicts   = 0;
  int short_verdicts = 0;

  crc16_frame_generate_check_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .out_kind_o     (out_kind_o),
    .check_status_o (check_status_o),
    .out_last_o     (out_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case a result never arrives or the input never unstalls
  initial begin
    #(TIMEOUT_UNITS);
    $display("DONE: errors detected");
    $finish;
  end

  // Fold the byte into the low end of the register, then shift out eight bits
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    c = crc ^ {8'h00, d};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endfunction

  function automatic void push_result(input logic [7:0] d, input logic [1:0] kind,
                                      input logic [1:0] status, input logic last);
    frame_result_t r;
    r = '{data: d, kind: kind, status: status, last: last};
    pending_results.push_back(r);
  endfunction

  // Advance the predictor by one accepted request and queue what it must produce
  function automatic void predict_byte(input logic op, input logic [7:0] d, input logic lst);
    logic [15:0] rx;
    logic [1:0]  verdict;
    if (!in_frame_m) begin
      // First byte of a frame: latch the mode, clear the CRC and the delay line
      mode_m     = op;
      crc_m      = CRC_SEED;
      held_n_m   = 2'd0;
      held_m[0]  = 8'h00;
      held_m[1]  = 8'h00;
      in_frame_m = 1'b1;
      if (op == MODE_GEN) gen_frames++;
      else chk_frames++;
    end
    if (mode_m == MODE_GEN) begin
      crc_m = crc16_step(crc_m, d);
      push_result(d, KIND_PAYLOAD, STAT_MATCH, 1'b0);
      if (lst) begin
        push_result(crc_m[15:8], KIND_CRC, STAT_MATCH, 1'b0);
        push_result(crc_m[7:0], KIND_CRC, STAT_MATCH, 1'b1);
        in_frame_m = 1'b0;
      end
    end else begin
      // Keep the last two bytes back; only bytes that leave the line enter the CRC
      if (held_n_m >= 2'd2) begin
        crc_m     = crc16_step(crc_m, held_m[0]);
        held_m[0] = held_m[1];
        held_m[1] = d;
      end else begin
        held_m[held_n_m[0]] = d;
        held_n_m++;
      end
      if (lst) begin
        if (held_n_m < 2'd2) begin
          verdict = STAT_SHORT;
          short_verdicts++;
        end else begin
          rx = {held_m[0], held_m[1]};
          verdict = (rx == crc_m) ? STAT_MATCH : STAT_MISMATCH;
          if (verdict == STAT_MATCH) match_verdicts++;
          else bad_verdicts++;
        end
        push_result(8'h00, KIND_VERDICT, verdict, 1'b1);
        in_frame_m = 1'b0;
      end
    end
  endfunction

  // Receiver: random stall, or a long hold-off whenever a test bumps hold_seq
  always @(posedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare every taken result against the oldest pending one
  always @(posedge clk_i) begin : result_check
    frame_result_t got;
    frame_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      got = '{data: out_byte_o, kind: out_kind_o, status: check_status_o, last: out_last_o};
      results_seen++;
      if (pending_results.size() == 0) begin
        note_error($sformatf("unexpected result @%0t: data=%02h kind=%0d status=%0d last=%0b",
                             $time, got.data, got.kind, got.status, got.last));
      end else begin
        want = pending_results.pop_front();
        if (got.data !== want.data || got.kind !== want.kind ||
            got.status !== want.status || got.last !== want.last) begin
          note_error($sformatf({"mismatch @%0t: expected data=%02h kind=%0d status=%0d ",
                                "last=%0b, got data=%02h kind=%0d status=%0d last=%0b"},
                               $time, want.data, want.kind, want.status, want.last,
                               got.data, got.kind, got.status, got.last));
        end
      end
    end
  end

  // Offer one request; hold the payload until the unit takes it
  task automatic send_req(input logic op, input logic [7:0] d, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    data_byte_i <= d;
    last_byte_i <= lst;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    predict_byte(op, d, lst);
    requests_sent++;
  endtask

  // Drop valid and wait until every pending result has been taken
  task automatic wait_for_results();
    int spins;
    in_valid_i <= 1'b0;
    spins = 0;
    while (pending_results.size() != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk_i);
      spins++;
    end
    if (pending_results.size() != 0) begin
      note_error($sformatf("%0d results never arrived @%0t", pending_results.size(), $time));
      error_count += pending_results.size() - 1;
      pending_results.delete();
    end
  endtask

  // Send a whole frame; op flips at random after the first byte and must be ignored.
  // Check frames can end in the right CRC, a corrupted one, or plain random bytes.
  task automatic send_frame(input logic mode, input int len, input int tail);
    logic [15:0] run_crc;
    logic [7:0]  d;
    int          flip_pos;
    run_crc  = CRC_SEED;
    flip_pos = len - 1 - $urandom_range(1);
    for (int i = 0; i < len; i++) begin
      if (mode == MODE_CHECK && tail != TAIL_RANDOM && len >= 2 && i >= len - 2) begin
        d = (i == len - 2) ? run_crc[15:8] : run_crc[7:0];
        if (tail == TAIL_CORRUPT && i == flip_pos) d = d ^ (8'h01 << $urandom_range(7));
      end else begin
        d = 8'($urandom_range(255));
        run_crc = crc16_step(run_crc, d);
      end
      send_req((i == 0) ? mode : logic'($urandom_range(1)), d, i == len - 1);
    end
  endtask

  // Generate frames: one-byte frames at both data extremes, op changes mid-frame
  task automatic test_generate_directed();
    send_req(MODE_GEN, 8'h00, 1'b1);
    send_req(MODE_GEN, 8'hFF, 1'b1);
    send_req(MODE_GEN, 8'h01, 1'b0);
    send_req(MODE_CHECK, 8'h80, 1'b0);
    send_req(MODE_CHECK, 8'hFE, 1'b1);
  endtask

  // Check frames: too short, empty payload, good CRC with op flips, corrupted CRC
  task automatic test_check_directed();
    logic [15:0] c;
    send_req(MODE_CHECK, 8'hA5, 1'b1);
    send_req(MODE_CHECK, 8'h00, 1'b0);
    send_req(MODE_CHECK, 8'h00, 1'b1);
    send_req(MODE_CHECK, 8'hFF, 1'b0);
    send_req(MODE_CHECK, 8'hFF, 1'b1);
    c = crc16_step(crc16_step(CRC_SEED, 8'hFF), 8'h00);
    send_req(MODE_CHECK, 8'hFF, 1'b0);
    send_req(MODE_GEN, 8'h00, 1'b0);
    send_req(MODE_GEN, c[15:8], 1'b0);
    send_req(MODE_CHECK, c[7:0], 1'b1);
    c = crc16_step(crc16_step(crc16_step(CRC_SEED, 8'h5A), 8'hC3), 8'h7E);
    send_req(MODE_CHECK, 8'h5A, 1'b0);
    send_req(MODE_CHECK, 8'hC3, 1'b0);
    send_req(MODE_CHECK, 8'h7E, 1'b0);
    send_req(MODE_CHECK, c[15:8], 1'b0);
    send_req(MODE_CHECK, c[7:0] ^ 8'h80, 1'b1);
    wait_for_results();
  endtask

  // Hold the output off for a long stretch while requests keep coming back to back
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_seq++;
    for (int f = 0; f < 3; f++) begin
      send_frame(MODE_GEN, 3, TAIL_RANDOM);
    end
    send_frame(MODE_CHECK, 3, TAIL_GOOD);
    wait_for_results();
  endtask

  // Pause the sender until the unit has emptied, then continue
  task automatic test_drain_pause();
    send_idle_pct = 37;
    recv_idle_pct = 45;
    send_frame(MODE_GEN, 2, TAIL_RANDOM);
    wait_for_results();
    send_frame(MODE_CHECK, 4, TAIL_GOOD);
    wait_for_results();
  endtask

  // Random frames, mostly short, mostly well-formed check tails
  task automatic test_random_frames(input int n_items, input int send_pct, input int recv_pct);
    int   sent_at_start;
    int   len;
    int   pick;
    int   tail;
    logic mode;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent_at_start = requests_sent;
    while (requests_sent - sent_at_start < n_items) begin
      mode = logic'($urandom_range(1));
      len  = ($urandom_range(99) < 85) ? $urandom_range(6, 1) : $urandom_range(24, 7);
      pick = $urandom_range(99);
      tail = (pick < 60) ? TAIL_GOOD : (pick < 80) ? TAIL_CORRUPT : TAIL_RANDOM;
      send_frame(mode, len, tail);
      if ($urandom_range(19) == 0) wait_for_results();
    end
    wait_for_results();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 37;
    recv_idle_pct = 45;
    test_generate_directed();
    test_check_directed();
    test_backpressure();
    test_drain_pause();
    test_random_frames(85, 37, 45);
    test_random_frames(85, 45, 37);
    test_random_frames(70, 0, 0);

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d requests in %0d generate and %0d check frames, %0d results taken",
             requests_sent, gen_frames, chk_frames, results_seen);
    $display("check verdicts seen: %0d match, %0d mismatch, %0d too short",
             match_verdicts, bad_verdicts, short_verdicts);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
